// ----- design/sclat_pkg.sv -----
package sclat_pkg;

  localparam int unsigned THREAD_SLOTS_DEF  = 256;
  localparam int unsigned PROCESS_SLOTS_DEF = 32;
  localparam int unsigned NCAT              = 8;
  localparam int unsigned NIPC              = 4;
  localparam logic [39:0] LIMIT_RESET       = 40'd10000000000;

  // request codes
  localparam logic [1:0] REQ_ENTER    = 2'd0;
  localparam logic [1:0] REQ_EXIT     = 2'd1;
  localparam logic [1:0] REQ_READ_CAT = 2'd2;
  localparam logic [1:0] REQ_READ_IPC = 2'd3;

  // entry kinds
  localparam logic KIND_CAT = 1'b0;
  localparam logic KIND_IPC = 1'b1;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_PEND,
    S_LAT,
    S_UPD,
    S_RD
  } state_e;

  // pending call word
  typedef struct packed {
    logic        valid;
    logic [9:0]  num;
    logic [63:0] start;
  } pend_t;

  // category statistics row
  typedef struct packed {
    logic [63:0] lat_max;
    logic [63:0] lat_min;
    logic [63:0] total;
    logic [63:0] errors;
    logic [63:0] count;
  } cat_row_t;

  // ipc statistics row
  typedef struct packed {
    logic [63:0] total;
    logic [63:0] count;
  } ipc_row_t;

  function automatic logic [2:0] call_category(input logic [9:0] n);
    logic [2:0] c;
    case (n)
      10'd0, 10'd1, 10'd2, 10'd3, 10'd4, 10'd5, 10'd6, 10'd7, 10'd8,
      10'd16, 10'd17, 10'd18, 10'd19, 10'd20, 10'd21, 10'd32, 10'd33,
      10'd40, 10'd72, 10'd73, 10'd74, 10'd75, 10'd76, 10'd77, 10'd78,
      10'd79, 10'd80, 10'd81, 10'd82, 10'd83, 10'd84, 10'd85, 10'd86,
      10'd87, 10'd88, 10'd89, 10'd90, 10'd91, 10'd92, 10'd93, 10'd94,
      10'd133, 10'd137, 10'd138, 10'd161, 10'd165, 10'd166, 10'd217,
      10'd257, 10'd258, 10'd259, 10'd260, 10'd261, 10'd262, 10'd263,
      10'd264, 10'd265, 10'd266, 10'd267, 10'd268, 10'd269, 10'd270,
      10'd271, 10'd275, 10'd276, 10'd277, 10'd278, 10'd280, 10'd285,
      10'd291, 10'd292, 10'd294, 10'd306, 10'd316, 10'd322, 10'd323:
        c = 3'd1;
      10'd41, 10'd42, 10'd43, 10'd44, 10'd45, 10'd46, 10'd47, 10'd48,
      10'd49, 10'd50, 10'd51, 10'd52, 10'd53, 10'd54, 10'd55, 10'd288,
      10'd299, 10'd307:
        c = 3'd2;
      10'd9, 10'd10, 10'd11, 10'd12, 10'd25, 10'd26, 10'd27, 10'd28,
      10'd29, 10'd30, 10'd31, 10'd67, 10'd149, 10'd150, 10'd151,
      10'd152, 10'd279, 10'd319:
        c = 3'd3;
      10'd24, 10'd39, 10'd56, 10'd57, 10'd58, 10'd59, 10'd60, 10'd61,
      10'd95, 10'd101, 10'd102, 10'd104, 10'd105, 10'd106, 10'd107,
      10'd108, 10'd109, 10'd110, 10'd111, 10'd112, 10'd113, 10'd114,
      10'd115, 10'd116, 10'd117, 10'd118, 10'd119, 10'd120, 10'd125,
      10'd126, 10'd155, 10'd157, 10'd158, 10'd186, 10'd231, 10'd247,
      10'd272, 10'd273, 10'd274, 10'd318, 10'd321:
        c = 3'd4;
      10'd22, 10'd293, 10'd64, 10'd65, 10'd66, 10'd220, 10'd68, 10'd69,
      10'd70, 10'd71, 10'd284, 10'd290, 10'd202, 10'd240:
        c = 3'd5;
      10'd35, 10'd36, 10'd37, 10'd38, 10'd96, 10'd201, 10'd222,
      10'd223, 10'd224, 10'd226, 10'd227, 10'd228, 10'd229, 10'd230,
      10'd283, 10'd286, 10'd287:
        c = 3'd6;
      10'd13, 10'd14, 10'd15, 10'd34, 10'd62, 10'd127, 10'd128,
      10'd129, 10'd130, 10'd131, 10'd200, 10'd234, 10'd282, 10'd289:
        c = 3'd7;
      default:
        c = 3'd0;
    endcase
    return c;
  endfunction

  // ipc kind 1..4, zero when the call is no ipc call
  function automatic logic [2:0] ipc_kind(input logic [9:0] n);
    logic [2:0] k;
    case (n)
      10'd22, 10'd293:                    k = 3'd1;
      10'd29, 10'd30, 10'd31, 10'd67:     k = 3'd2;
      10'd202, 10'd240:                   k = 3'd3;
      10'd68, 10'd69, 10'd70, 10'd71:     k = 3'd4;
      default:                            k = 3'd0;
    endcase
    return k;
  endfunction

endpackage

// ----- design/sclat_alu.sv -----
module sclat_alu (
  input  sclat_pkg::cat_row_t cat_i,
  input  sclat_pkg::ipc_row_t ipc_i,
  input  logic [63:0]         lat_i,
  input  logic                err_i,
  output sclat_pkg::cat_row_t cat_o,
  output sclat_pkg::ipc_row_t ipc_o
);
  import sclat_pkg::*;

  // category row update
  always_comb begin
    cat_o        = cat_i;
    cat_o.count  = cat_i.count + 64'd1;
    cat_o.errors = cat_i.errors + {63'd0, err_i};
    if (lat_i != 64'd0) begin
      cat_o.total = cat_i.total + lat_i;
      if ((lat_i < cat_i.lat_min) || (cat_i.lat_min == 64'd0)) begin
        cat_o.lat_min = lat_i;
      end
      if (lat_i > cat_i.lat_max) begin
        cat_o.lat_max = lat_i;
      end
    end
  end

  // ipc row update
  always_comb begin
    ipc_o.count = ipc_i.count + 64'd1;
    ipc_o.total = ipc_i.total + lat_i;
  end

endmodule

// ----- design/syscall_latency_stats_core.sv -----
// sequence: a read request reads the statistics memory, then the result register takes the
// result once free and holds it until taken; an enter ends on acceptance; an exit steps
// through pending read, stats read and latency, limit, and write back; an ignored exit ends
// on acceptance, and an exit with no pending call ends after the pending read
// flow: one request at a time, bound by the single-port read-modify-write of the statistics
// memories, and a read waits while a result is not taken; reset: asynchronous active low;
// afterwards a clearing pass zeroes all memories before the first request
module syscall_latency_stats_core #(
  parameter int unsigned THREAD_SLOTS  = sclat_pkg::THREAD_SLOTS_DEF,
  parameter int unsigned PROCESS_SLOTS = sclat_pkg::PROCESS_SLOTS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration: latency_limit_ns
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [39:0]  cfg_data_i,
  // request stream
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  // thread_slot, process_slot, process_id, timestamp_ns, syscall_number,
  // return_value, entry_select, zero fill
  input  logic [191:0] s_tdata_i,
  // req_type
  input  logic [1:0]   s_tuser_i,
  // result stream
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  // event_count, failed call count, latency_total, latency_min, latency_max
  output logic [319:0] m_tdata_o,
  // entry_kind
  output logic         m_tuser_o
);
  import sclat_pkg::*;

  localparam int unsigned TW      = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
  localparam int unsigned PW      = (PROCESS_SLOTS > 1) ? $clog2(PROCESS_SLOTS) : 1;
  localparam int unsigned T_DEPTH = 2 ** TW;
  localparam int unsigned C_DEPTH = (2 ** PW) * NCAT;
  localparam int unsigned I_DEPTH = (2 ** PW) * NIPC;
  localparam int unsigned CLR_N   = (T_DEPTH > C_DEPTH) ? T_DEPTH : C_DEPTH;
  localparam int unsigned CLW     = $clog2(CLR_N);

  // request fields
  logic [7:0]  in_tslot;
  logic [4:0]  in_pslot;
  logic [31:0] in_pid;
  logic [63:0] in_ts;
  logic [9:0]  in_num;
  logic [63:0] in_ret;
  logic [2:0]  in_sel;
  logic [15:0] in_tslot_w;
  logic [15:0] in_pslot_w;
  logic [TW-1:0] in_tidx;
  logic [PW-1:0] in_pidx;
  logic        in_t_ok;
  logic        in_p_ok;

  assign in_tslot   = s_tdata_i[7:0];
  assign in_pslot   = s_tdata_i[12:8];
  assign in_pid     = s_tdata_i[44:13];
  assign in_ts      = s_tdata_i[108:45];
  assign in_num     = s_tdata_i[118:109];
  assign in_ret     = s_tdata_i[182:119];
  assign in_sel     = s_tdata_i[185:183];
  assign in_tslot_w = {8'd0, in_tslot};
  assign in_pslot_w = {11'd0, in_pslot};
  assign in_tidx    = in_tslot_w[TW-1:0];
  assign in_pidx    = in_pslot_w[PW-1:0];
  assign in_t_ok    = 32'(in_tslot) < THREAD_SLOTS;
  assign in_p_ok    = 32'(in_pslot) < PROCESS_SLOTS;

  state_e state_q, state_d;
  logic [CLW-1:0] clr_cnt_q;
  logic [39:0]    limit_q;
  logic           accept;

  // registered request
  logic [1:0]    req_q;
  logic [TW-1:0] tidx_q;
  logic [PW-1:0] pidx_q;
  logic [63:0]   ts_q;
  logic          err_q;
  logic [2:0]    sel_q;
  logic          p_ok_q;
  logic [63:0]   diff_q;
  logic [63:0]   lat_q;
  logic [2:0]    kind_q;
  logic [2:0]    cat_q;

  // memories
  pend_t    pend_mem [T_DEPTH];
  cat_row_t cat_mem  [C_DEPTH];
  ipc_row_t ipc_mem  [I_DEPTH];
  pend_t    pend_rd_q;
  cat_row_t cat_rd_q;
  ipc_row_t ipc_rd_q;

  logic          pend_we, pend_re;
  logic [TW-1:0] pend_addr;
  pend_t         pend_wd;
  logic          cat_we, cat_re, ipc_we, ipc_re;
  logic [PW+2:0] cat_addr;
  logic [PW+1:0] ipc_addr;
  cat_row_t      cat_wd, cat_new;
  ipc_row_t      ipc_wd, ipc_new;
  logic [2:0]    ex_cat, ex_kind, rd_kind;
  logic          clr_done;

  // output register
  logic         m_valid_q;
  logic [319:0] m_data_q;
  logic         m_kind_q;
  logic         out_free;

  assign cfg_ready_o = 1'b1;
  assign s_tready_o  = (state_q == S_IDLE);
  assign accept      = s_tvalid_i & s_tready_o;
  assign out_free    = !m_valid_q || m_tready_i;
  assign clr_done    = (32'(clr_cnt_q) == CLR_N - 1);
  assign m_tvalid_o  = m_valid_q;
  assign m_tdata_o   = m_data_q;
  assign m_tuser_o   = m_kind_q;

  // classification of the pending call, and the ipc kind of a read request
  assign ex_cat  = call_category(pend_rd_q.num);
  assign ex_kind = ipc_kind(pend_rd_q.num);
  assign rd_kind = in_sel - 3'd1;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLR: begin
        if (clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          case (s_tuser_i)
            REQ_EXIT: begin
              if (in_pid != 32'd0 && in_t_ok && in_p_ok) state_d = S_PEND;
            end
            REQ_READ_CAT, REQ_READ_IPC: state_d = S_RD;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_PEND: begin
        state_d = pend_rd_q.valid ? S_LAT : S_IDLE;
      end
      S_LAT: state_d = S_UPD;
      S_UPD: state_d = S_IDLE;
      S_RD: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    pend_we   = 1'b0;
    pend_re   = 1'b0;
    pend_addr = in_tidx;
    pend_wd   = '{valid: 1'b1, num: in_num, start: in_ts};
    cat_we    = 1'b0;
    cat_re    = 1'b0;
    cat_addr  = {in_pidx, in_sel};
    cat_wd    = cat_new;
    ipc_we    = 1'b0;
    ipc_re    = 1'b0;
    ipc_addr  = {in_pidx, rd_kind[1:0]};
    ipc_wd    = ipc_new;
    case (state_q)
      S_CLR: begin
        pend_addr = clr_cnt_q[TW-1:0];
        pend_wd   = '0;
        pend_we   = 32'(clr_cnt_q) < T_DEPTH;
        cat_addr  = clr_cnt_q[PW+2:0];
        cat_wd    = '0;
        cat_we    = 32'(clr_cnt_q) < C_DEPTH;
        ipc_addr  = clr_cnt_q[PW+1:0];
        ipc_wd    = '0;
        ipc_we    = 32'(clr_cnt_q) < I_DEPTH;
      end
      S_IDLE: begin
        if (accept) begin
          case (s_tuser_i)
            REQ_ENTER: pend_we = (in_pid != 32'd0) && in_t_ok;
            REQ_EXIT: pend_re = 1'b1;
            REQ_READ_CAT: cat_re = 1'b1;
            REQ_READ_IPC: ipc_re = 1'b1;
            default: pend_re = 1'b0;
          endcase
        end
      end
      S_PEND: begin
        cat_addr = {pidx_q, ex_cat};
        ipc_addr = {pidx_q, 2'(ex_kind - 3'd1)};
        cat_re   = pend_rd_q.valid;
        ipc_re   = pend_rd_q.valid && (ex_kind != 3'd0);
      end
      S_UPD: begin
        pend_addr = tidx_q;
        pend_wd   = '0;
        pend_we   = 1'b1;
        cat_addr  = {pidx_q, cat_q};
        cat_we    = 1'b1;
        ipc_addr  = {pidx_q, 2'(kind_q - 3'd1)};
        ipc_we    = (kind_q != 3'd0);
      end
      default: pend_we = 1'b0;
    endcase
  end

  // pending call memory
  always_ff @(posedge clk_i) begin
    if (pend_we) pend_mem[pend_addr] <= pend_wd;
    if (pend_re) pend_rd_q <= pend_mem[pend_addr];
  end

  // category statistics memory
  always_ff @(posedge clk_i) begin
    if (cat_we) cat_mem[cat_addr] <= cat_wd;
    if (cat_re) cat_rd_q <= cat_mem[cat_addr];
  end

  // ipc statistics memory
  always_ff @(posedge clk_i) begin
    if (ipc_we) ipc_mem[ipc_addr] <= ipc_wd;
    if (ipc_re) ipc_rd_q <= ipc_mem[ipc_addr];
  end

  sclat_alu u_alu (
    .cat_i (cat_rd_q),
    .ipc_i (ipc_rd_q),
    .lat_i (lat_q),
    .err_i (err_q),
    .cat_o (cat_new),
    .ipc_o (ipc_new)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      clr_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // request capture and latency datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= s_tuser_i;
      tidx_q <= in_tidx;
      pidx_q <= in_pidx;
      ts_q   <= in_ts;
      err_q  <= in_ret[63];
      sel_q  <= in_sel;
      p_ok_q <= in_p_ok;
    end
    if (state_q == S_PEND) begin
      diff_q <= ts_q - pend_rd_q.start;
      cat_q  <= ex_cat;
      kind_q <= ex_kind;
    end
    if (state_q == S_LAT) begin
      lat_q <= (diff_q > {24'd0, limit_q}) ? 64'd0 : diff_q;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (state_q == S_RD && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RD && out_free) begin
      if (req_q == REQ_READ_CAT) begin
        m_kind_q <= KIND_CAT;
        m_data_q <= p_ok_q ? cat_rd_q : '0;
      end else begin
        m_kind_q <= KIND_IPC;
        if (p_ok_q && sel_q >= 3'd1 && sel_q <= 3'd4) begin
          m_data_q <= {128'd0, ipc_rd_q.total, 64'd0, ipc_rd_q.count};
        end else begin
          m_data_q <= '0;
        end
      end
    end
  end

  // no request is taken during the clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> !s_tready_o)
    else $error("request accepted while clearing");

  // a new result appears only out of the read state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == S_RD))
    else $error("result raised outside read");

  // statistics are written back only in the update step of a valid exit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> ($past(state_q, 2) == S_PEND))
    else $error("update without pending read");

  // an exit enters the latency step only with a valid pending entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PEND && state_d == S_LAT) |-> pend_rd_q.valid)
    else $error("exit used stale pending entry");

endmodule
